// ===== design/upq_pkg.sv =====
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types and codes of the unsorted priority queue: operation codes,
// status codes and the request record passed from front to back.
// ----------------------------------------------------------------------------
package upq_pkg;

   typedef logic        [1:0]  op_type;
   typedef logic        [1:0]  status_type;
   typedef logic signed [31:0] value_type;

   // operation codes
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_XMAX   = 2'd1;
   localparam op_type OP_XMIN   = 2'd2;
   localparam op_type OP_SEARCH = 2'd3;

   // status codes
   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_REFUSED   = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   localparam int unsigned ENTRIES_W = 7;

   // request as classified by the front part
   typedef struct packed {
      op_type    op;
      value_type value;
   } cmd_type;

endpackage

// ===== design/upq_front.sv =====
// ----------------------------------------------------------------------------
// upq_front
// Request side: accepts requests, decodes the operation and holds them in a
// two-entry queue until the back part takes them.
// ----------------------------------------------------------------------------
module upq_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_kind,
   input  upq_pkg::value_type         req_value,
   output logic                       cmd_valid,
   output upq_pkg::cmd_type           cmd,
   input  logic                       cmd_pop
);

   upq_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   upq_pkg::cmd_type decoded;
   logic             push_ok, pop_ok;

   // operation decode
   always_comb begin
      decoded.value = req_value;
      unique case (req_kind)
         upq_pkg::OP_INSERT: decoded.op = upq_pkg::OP_INSERT;
         upq_pkg::OP_XMAX:   decoded.op = upq_pkg::OP_XMAX;
         upq_pkg::OP_XMIN:   decoded.op = upq_pkg::OP_XMIN;
         default:            decoded.op = upq_pkg::OP_SEARCH;
      endcase
   end

   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_ok && !pop_ok) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/upq_back.sv =====
// ----------------------------------------------------------------------------
// upq_back
// Execution side: holds the value store in a one-read one-write memory, scans
// it one entry per cycle for extractions and searches, and keeps the result
// register that feeds the response side.
// ----------------------------------------------------------------------------
module upq_back #(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  upq_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output upq_pkg::status_type        rsp_status,
   output upq_pkg::value_type         rsp_result_value,
   output logic [upq_pkg::ENTRIES_W-1:0] rsp_entries
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   upq_pkg::value_type mem [CAPACITY];

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_idx_ff;
   upq_pkg::value_type  rd_data_ff;
   upq_pkg::op_type     op_ff, op_in;
   upq_pkg::value_type  key_ff, key_in;
   logic                found_ff, found_in;
   upq_pkg::value_type  best_val_ff, best_val_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   upq_pkg::value_type  last_val_ff, last_val_in;

   logic                rsp_valid_ff;
   upq_pkg::status_type rsp_status_ff;
   upq_pkg::value_type  rsp_value_ff;
   logic [upq_pkg::ENTRIES_W-1:0] rsp_entries_ff;

   logic                res_load;
   upq_pkg::status_type res_status;
   upq_pkg::value_type  res_value;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   upq_pkg::value_type  mem_wdata;

   logic [CW-1:0]       count_m1;
   logic [AW-1:0]       last_idx;
   logic                out_free;
   logic                is_full;
   logic                better;

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign is_full  = (count_ff >= CW'(CAPACITY));
   assign better   = (op_ff == upq_pkg::OP_XMAX) ? (rd_data_ff > best_val_ff)
                                                 : (rd_data_ff < best_val_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      issue_in    = issue_ff;
      rd_valid_in = (state_ff == S_SCAN) && issue_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      found_in    = found_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      last_val_in = last_val_ff;
      cmd_pop     = 1'b0;
      res_load    = 1'b0;
      res_status  = upq_pkg::ST_DONE;
      res_value   = '0;
      mem_we      = 1'b0;
      mem_waddr   = count_ff[AW-1:0];
      mem_wdata   = cmd.value;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               // start scan for extractions and searches
               op_in    = cmd.op;
               key_in   = cmd.value;
               idx_in   = '0;
               issue_in = 1'b1;
               found_in = 1'b0;
               unique case (cmd.op)
                  upq_pkg::OP_INSERT: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        res_load = 1'b1;
                        if (is_full) begin
                           res_status = upq_pkg::ST_FULL;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  upq_pkg::OP_XMAX, upq_pkg::OP_XMIN: begin
                     if (count_ff <= CW'(1)) begin
                        if (out_free) begin
                           cmd_pop    = 1'b1;
                           res_load   = 1'b1;
                           res_status = upq_pkg::ST_REFUSED;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_pop    = 1'b1;
                           res_load   = 1'b1;
                           res_status = upq_pkg::ST_NOT_FOUND;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read address stage
            if (issue_ff) begin
               if (idx_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
            // compare stage on the registered read data
            if (rd_valid_ff) begin
               if (op_ff == upq_pkg::OP_SEARCH) begin
                  if (rd_data_ff == key_ff) begin
                     found_in = 1'b1;
                  end
               end else if ((rd_idx_ff == '0) || better) begin
                  best_val_in = rd_data_ff;
                  best_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == last_idx) begin
                  last_val_in = rd_data_ff;
                  state_in    = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
               if (op_ff == upq_pkg::OP_SEARCH) begin
                  res_status = found_ff ? upq_pkg::ST_DONE : upq_pkg::ST_NOT_FOUND;
                  res_value  = found_ff ? key_ff : '0;
               end else begin
                  // fill the hole with the last entry
                  mem_we    = 1'b1;
                  mem_waddr = best_idx_ff;
                  mem_wdata = last_val_ff;
                  count_in  = count_m1;
                  res_value = best_val_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         issue_ff    <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rd_idx_ff   <= idx_ff;
      op_ff       <= op_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      last_val_ff <= last_val_in;
   end

   // value store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status_ff  <= res_status;
         rsp_value_ff   <= res_value;
         rsp_entries_ff <= upq_pkg::ENTRIES_W'(count_in);
      end
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_entries      = rsp_entries_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SCAN))
      else $error("read data outside a scan");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (res_load && (res_status == upq_pkg::ST_REFUSED)) |=> (count_ff == $past(count_ff)))
      else $error("refused extraction changed the count");

   a_no_load_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pop) |-> !res_load)
      else $error("result overwritten before it was taken");

endmodule

// ===== design/unsorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// unsorted_priority_queue
// Double-ended priority queue over an unordered store of signed values.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through req_push/req_full: a request is taken at an edge
//   with req_push high and req_full low. req_kind selects insert, extract
//   maximum, extract minimum or search; req_value is the operand.
//   Each request yields exactly one response, held on rsp_* while rsp_empty
//   is low and removed at an edge with rsp_pop high.
//   An insert, and a refused or trivially answered request, is answered
//   by the execution unit from its idle state. An extraction or search scans
//   the store one entry per cycle through the memory read port and then
//   writes its result from a finish state.
//   A two-entry request queue accepts new requests while a scan runs.
//   If the receiver stalls, the finished response waits in the result
//   register, the execution unit holds its next result, and the request
//   queue fills and raises req_full.
//   Reset empties the store and both queues; store contents are not cleared
//   and need no clearing pass.
// ----------------------------------------------------------------------------
module unsorted_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_kind,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_status,
   output logic signed [31:0]            rsp_result_value,
   output logic [upq_pkg::ENTRIES_W-1:0] rsp_entries
);

   logic             cmd_valid;
   logic             cmd_pop;
   upq_pkg::cmd_type cmd;

   // request side
   upq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // execution side
   upq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_entries      (rsp_entries)
   );

endmodule
